// ----- hdl/mm3_pkg.sv -----
// Shared types, constants and codes for the MurmurHash3 x86_32 stream hash.
// Used by the front, the back, the top and the testbench; depends on nothing else.
package mm3_pkg;

  localparam logic [31:0] C1   = 32'hcc9e2d51;
  localparam logic [31:0] C2   = 32'h1b873593;
  localparam logic [31:0] HADD = 32'he6546b64;
  localparam logic [31:0] F1   = 32'h85ebca6b;
  localparam logic [31:0] F2   = 32'hc2b2ae35;

  localparam logic [2:0] WORD_BYTES = 3'd4;

  // Default depths of the queue between front and back and of the result queue.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned ODEPTH = 4;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_TAIL,
    KIND_FULL
  } kind_e;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_MIX1,
    ST_MIX2,
    ST_MIX3
  } back_state_e;

  // One classified word on its way from the front to the back.
  typedef struct packed {
    logic [31:0] k;
    logic [31:0] seed;
    logic [2:0]  cnt;
    kind_e       kind;
    logic        last;
    logic        first;
  } op_t;

endpackage

// ----- hdl/mm3_queue.sv -----
// Small first-in first-out queue in flip-flops, one write and one read per cycle.
// Stand-alone; used between front and back and for the results.
module mm3_queue #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4,
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic [CntW-1:0]  count_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

// ----- hdl/mm3_front.sv -----
// Front part: takes input beats, masks and classifies each word and runs the k-mix
// over two multiplier stages. Depends on mm3_pkg.
module mm3_front import mm3_pkg::*; #(
  parameter int unsigned QueueDepth = QDEPTH,
  localparam int unsigned CntW = $clog2(QueueDepth + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic [31:0]     data_word_i,
  input  logic [2:0]      byte_count_i,
  input  logic            last_i,
  input  logic [31:0]     seed_i,
  output logic            full_o,
  input  logic [CntW-1:0] q_count_i,
  output logic            q_push_o,
  output op_t             q_op_o
);

  logic        accept;
  logic [2:0]  cnt;
  logic [31:0] masked;
  kind_e       kind;
  logic [31:0] k2_in;
  logic [CntW:0] reserved;

  logic first_q, first_d;
  logic s1_v_q, s2_v_q;
  op_t  s1_op_q, s1_op_d;
  op_t  s2_op_q, s2_op_d;

  // Credit check: every beat in the two stages already owns a queue slot.
  assign reserved = (CntW + 1)'(q_count_i) + (CntW + 1)'(s1_v_q) + (CntW + 1)'(s2_v_q);
  assign full_o   = reserved >= (CntW + 1)'(QueueDepth);
  assign accept   = push_i && !full_o;

  always_comb begin
    cnt = (byte_count_i > WORD_BYTES) ? WORD_BYTES : byte_count_i;
    case (cnt)
      3'd0:    masked = '0;
      3'd1:    masked = {24'h0, data_word_i[7:0]};
      3'd2:    masked = {16'h0, data_word_i[15:0]};
      3'd3:    masked = {8'h0, data_word_i[23:0]};
      default: masked = data_word_i;
    endcase
    if (cnt == WORD_BYTES) begin
      kind = KIND_FULL;
    end else if (cnt == 3'd0) begin
      kind = KIND_NONE;
    end else begin
      kind = KIND_TAIL;
    end

    s1_op_d       = s1_op_q;
    s1_op_d.k     = 32'(masked * C1);
    s1_op_d.seed  = seed_i;
    s1_op_d.cnt   = cnt;
    s1_op_d.kind  = kind;
    s1_op_d.last  = last_i;
    s1_op_d.first = first_q;

    k2_in     = {s1_op_q.k[16:0], s1_op_q.k[31:17]};
    s2_op_d   = s1_op_q;
    s2_op_d.k = 32'(k2_in * C2);

    first_d = accept ? last_i : first_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
    end else begin
      first_q <= first_d;
      s1_v_q  <= accept;
      s2_v_q  <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q <= s1_op_d;
    end
    if (s1_v_q) begin
      s2_op_q <= s2_op_d;
    end
  end

  assign q_push_o = s2_v_q;
  assign q_op_o   = s2_op_q;

endmodule

// ----- hdl/mm3_back.sv -----
// Back part: folds mixed words into the running hash and length, then runs
// fmix32 over three steps and hands the hash to the result queue. Depends on mm3_pkg.
module mm3_back import mm3_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  op_t         q_op_i,
  output logic        q_pop_o,
  input  logic        out_full_i,
  output logic        out_push_o,
  output logic [31:0] out_hash_o
);

  back_state_e state_q, state_d;
  logic [31:0] hash_q, hash_d;
  logic [31:0] len_q, len_d;
  logic [31:0] fin_q, fin_d;

  logic [31:0] h_base, h_x, h_rot, h_full, len_new, x1, x2;

  always_comb begin
    state_d    = state_q;
    hash_d     = hash_q;
    len_d      = len_q;
    fin_d      = fin_q;
    q_pop_o    = 1'b0;
    out_push_o = 1'b0;

    h_base  = q_op_i.first ? q_op_i.seed : hash_q;
    len_new = (q_op_i.first ? 32'h0 : len_q) + 32'(q_op_i.cnt);
    h_x     = h_base ^ q_op_i.k;
    h_rot   = {h_x[18:0], h_x[31:19]};
    h_full  = {h_rot[29:0], 2'b00} + h_rot + HADD;
    x1      = fin_q ^ len_q;
    x2      = x1 ^ (x1 >> 16);
    out_hash_o = fin_q ^ (fin_q >> 16);

    case (state_q)
      ST_RUN: begin
        // A last word waits until the result queue has room for its hash.
        if (!q_empty_i && !(q_op_i.last && out_full_i)) begin
          q_pop_o = 1'b1;
          case (q_op_i.kind)
            KIND_FULL: fin_d = h_full;
            KIND_TAIL: fin_d = h_x;
            default:   fin_d = h_base;
          endcase
          len_d = len_new;
          if (q_op_i.last) begin
            state_d = ST_MIX1;
          end else begin
            hash_d = fin_d;
          end
        end
      end
      ST_MIX1: begin
        fin_d   = 32'(x2 * F1);
        hash_d  = '0;
        len_d   = '0;
        state_d = ST_MIX2;
      end
      ST_MIX2: begin
        fin_d   = 32'((fin_q ^ (fin_q >> 13)) * F2);
        state_d = ST_MIX3;
      end
      ST_MIX3: begin
        out_push_o = 1'b1;
        state_d    = ST_RUN;
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      hash_q  <= '0;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      hash_q  <= hash_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fin_q <= fin_d;
  end

endmodule

// ----- hdl/murmur3_32_stream_hash_top.sv -----
// MurmurHash3 x86_32 over a stream of little-endian words. A beat passes the front's
// stages s1 and s2 and the op queue before the back takes it.
// Throughput: one word per cycle while full is low, for words that do not end a message;
// a last word holds the back part while the fmix32 states ST_MIX1 to ST_MIX3 run.
// Reset is asynchronous, active low: queues empty, next word starts a message.
// Depends on mm3_pkg, mm3_front, mm3_queue and mm3_back.
module murmur3_32_stream_hash_top import mm3_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QDEPTH,
  parameter int unsigned OUT_DEPTH   = ODEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_i,
  input  logic [31:0] seed_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] hash_o
);

  localparam int unsigned QCntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OCntW = $clog2(OUT_DEPTH + 1);

  logic                    q_push, q_pop, q_empty;
  op_t                     q_op_in, q_op_out;
  logic [$bits(op_t)-1:0]  q_raw_out;
  logic [QCntW-1:0]        q_count;
  logic                    out_push, out_pop, out_full;
  logic [31:0]             out_hash;
  logic [OCntW-1:0]        out_count;

  mm3_front #(
    .QueueDepth(QUEUE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_word_i (data_word_i),
    .byte_count_i(byte_count_i),
    .last_i      (last_i),
    .seed_i      (seed_i),
    .full_o      (full),
    .q_count_i   (q_count),
    .q_push_o    (q_push),
    .q_op_o      (q_op_in)
  );

  mm3_queue #(
    .Width($bits(op_t)),
    .Depth(QUEUE_DEPTH)
  ) u_op_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_op_in),
    .pop_i  (q_pop),
    .data_o (q_raw_out),
    .count_o(q_count)
  );

  assign q_op_out = op_t'(q_raw_out);
  assign q_empty  = (q_count == '0);

  mm3_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_op_i    (q_op_out),
    .q_pop_o   (q_pop),
    .out_full_i(out_full),
    .out_push_o(out_push),
    .out_hash_o(out_hash)
  );

  mm3_queue #(
    .Width(32),
    .Depth(OUT_DEPTH)
  ) u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .data_i (out_hash),
    .pop_i  (out_pop),
    .data_o (hash_o),
    .count_o(out_count)
  );

  assign out_full = (out_count == OCntW'(OUT_DEPTH));
  assign empty    = (out_count == '0);
  assign out_pop  = pop && !empty;

  // The front's credit scheme must never push into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (q_count < QCntW'(QUEUE_DEPTH)))
    else $error("op queue overflow");

  // The back reserves result space before it starts a finalisation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> (out_count < OCntW'(OUT_DEPTH)))
    else $error("result queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("back popped an empty op queue");

  // A hash leaves the back in ST_MIX3, reached through ST_MIX1 and ST_MIX2 after its last word was taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && q_op_out.last) |-> ##3 out_push)
    else $error("finalisation did not complete in three cycles");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for murmur3_32_stream_hash_top: messages of random words and lengths,
// hashed by a local MurmurHash3 x86_32 predictor and compared hash by hash at the result queue.
// Depends on mm3_pkg for the mixing constants and on the top module of the block.
module tb;
  import mm3_pkg::*;

  typedef struct {
    logic [31:0] data;
    logic [2:0]  cnt;
    logic        last;
    logic [31:0] seed;
  } word_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] data_word_i = '0;
  logic [2:0]  byte_count_i = '0;
  logic        last_i = 1'b0;
  logic [31:0] seed_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] hash_o;

  word_beat_t  word_queue[$];
  logic [31:0] hash_expected[$];
  word_beat_t  driven_word;

  // Predictor state: hash so far, bytes so far, and whether a message is open.
  logic [31:0] msg_hash = '0;
  logic [31:0] msg_bytes = '0;
  logic        msg_open = 1'b0;

  int unsigned words_sent = 0;
  int unsigned hashes_popped = 0;
  int unsigned error_count = 0;

  murmur3_32_stream_hash_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .seed_i       (seed_i),
    .empty        (empty),
    .pop          (pop),
    .hash_o       (hash_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] scramble_k(logic [31:0] k);
    logic [31:0] t;
    t = k * C1;
    t = {t[16:0], t[31:17]};
    return t * C2;
  endfunction

  function automatic logic [31:0] avalanche(logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 16);
    t = t * F1;
    t = t ^ (t >> 13);
    t = t * F2;
    return t ^ (t >> 16);
  endfunction

  // Folds one accepted beat into the running hash; a last beat yields the finished hash.
  task automatic murmur_absorb(input word_beat_t b);
    logic [31:0] h;
    logic [2:0]  n;
    logic [31:0] mask;
    n = (b.cnt > 3'd4) ? 3'd4 : b.cnt;
    if (!msg_open) begin
      msg_hash  = b.seed;
      msg_bytes = '0;
    end
    h = msg_hash;
    if (n == 3'd4) begin
      h = h ^ scramble_k(b.data);
      h = {h[18:0], h[31:19]};
      h = h * 32'd5 + HADD;
    end else if (n != 3'd0) begin
      mask = (32'd1 << (8 * n)) - 32'd1;
      h = h ^ scramble_k(b.data & mask);
    end
    msg_bytes = msg_bytes + 32'(n);
    if (b.last) begin
      hash_expected.push_back(avalanche(h ^ msg_bytes));
      msg_hash  = '0;
      msg_bytes = '0;
      msg_open  = 1'b0;
    end else begin
      msg_hash = h;
      msg_open = 1'b1;
    end
  endtask

  // Idles with a chance of eight in a hundred, except over a stretch of steady traffic.
  function automatic bit sender_idles();
    if (words_sent >= 150 && words_sent < 260) return 1'b0;
    return $urandom_range(99) < 8;
  endfunction

  function automatic bit receiver_stalls();
    if (hashes_popped >= 40 && hashes_popped < 80) return 1'b0;
    return $urandom_range(99) < 8;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push         <= 1'b0;
      data_word_i  <= '0;
      byte_count_i <= '0;
      last_i       <= 1'b0;
      seed_i       <= '0;
    end else begin
      if (push && !full) begin
        murmur_absorb(driven_word);
        words_sent++;
      end
      if (!push || !full) begin
        if (word_queue.size() != 0 && !sender_idles()) begin
          driven_word   = word_queue.pop_front();
          push         <= 1'b1;
          data_word_i  <= driven_word.data;
          byte_count_i <= driven_word.cnt;
          last_i       <= driven_word.last;
          seed_i       <= driven_word.seed;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        hashes_popped++;
        if (hash_expected.size() == 0) begin
          $display("%0t: unexpected hash, expected none, got %h", $time, hash_o);
          error_count++;
        end else begin
          if (hash_o !== hash_expected[0]) begin
            $display("%0t: hash mismatch, expected %h, got %h", $time, hash_expected[0], hash_o);
            error_count++;
          end
          void'(hash_expected.pop_front());
        end
      end
      pop <= !receiver_stalls();
    end
  end

  task automatic queue_word(input logic [31:0] data, input logic [2:0] cnt, input logic last,
                            input logic [31:0] seed);
    word_beat_t b;
    b.data = data;
    b.cnt  = cnt;
    b.last = last;
    b.seed = seed;
    word_queue.push_back(b);
  endtask

  // A well-formed message has full words, some counted above four, and a final word of 0 to 4
  // bytes; a noisy one takes any count on any word, partial and zero counts mid-message included.
  task automatic queue_message(input int unsigned n_words, input bit noisy);
    logic [2:0]  cnt;
    logic [31:0] seed;
    for (int unsigned i = 0; i < n_words; i++) begin
      if (noisy) cnt = 3'($urandom_range(7));
      else if (i + 1 == n_words) cnt = 3'($urandom_range(4));
      else if ($urandom_range(9) == 0) cnt = 3'($urandom_range(7, 5));
      else cnt = 3'd4;
      case ($urandom_range(9))
        0: seed = '0;
        1: seed = '1;
        default: seed = $urandom;
      endcase
      queue_word($urandom, cnt, i + 1 == n_words, seed);
    end
  endtask

  initial begin
    // Empty message with the extreme seeds.
    queue_word(32'h0, 3'd0, 1'b1, 32'h0);
    queue_word(32'hffffffff, 3'd0, 1'b1, 32'hffffffff);
    // Single-word messages of each byte count; bytes beyond the count are set.
    queue_word(32'hffffffff, 3'd1, 1'b1, 32'h0);
    queue_word(32'hffffffff, 3'd2, 1'b1, 32'hffffffff);
    queue_word(32'hffffffff, 3'd3, 1'b1, 32'h12345678);
    queue_word(32'hffffffff, 3'd4, 1'b1, 32'hffffffff);
    queue_word(32'h0, 3'd4, 1'b1, 32'h0);
    // Counts above four count as four, on last and non-last words.
    queue_word(32'hdeadbeef, 3'd5, 1'b0, 32'h9747b28c);
    queue_word(32'h01234567, 3'd6, 1'b0, 32'hffffffff);
    queue_word(32'h89abcdef, 3'd7, 1'b1, 32'h0);
    // A zero count on the first word still takes the seed.
    queue_word(32'hffffffff, 3'd0, 1'b0, 32'haaaaaaaa);
    queue_word(32'h55555555, 3'd4, 1'b0, 32'h0);
    queue_word(32'h00ffff00, 3'd2, 1'b1, 32'hffffffff);
    // A partial word in the middle of a message, then more words.
    queue_word(32'h11223344, 3'd4, 1'b0, 32'h0);
    queue_word(32'haabbccdd, 3'd3, 1'b0, 32'h0);
    queue_word(32'h0, 3'd0, 1'b0, 32'hffffffff);
    queue_word(32'hcafef00d, 3'd4, 1'b0, 32'h0);
    queue_word(32'h77777777, 3'd1, 1'b1, 32'h0);
    // Word-aligned message closed by a zero-count last word.
    queue_word(32'h61626364, 3'd4, 1'b0, 32'h5eed5eed);
    queue_word(32'h65666768, 3'd4, 1'b0, 32'h0);
    queue_word(32'hffffffff, 3'd0, 1'b1, 32'h0);
    while (word_queue.size() < 420) queue_message($urandom_range(8, 1), $urandom_range(99) < 15);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (word_queue.size() != 0 || push) @(posedge clk_i);
    while (hash_expected.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("murmur3_32_stream_hash_top test passed");
    end else begin
      $display("murmur3_32_stream_hash_top test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("murmur3_32_stream_hash_top test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/mm3_pkg.sv
hdl/mm3_queue.sv
hdl/mm3_front.sv
hdl/mm3_back.sv
hdl/murmur3_32_stream_hash_top.sv
tb/tb.sv
